// ===== src/metafile_record_walker_object_alloc_unit_macros.svh =====
// Assertion macros used by the record walker back end.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef METAFILE_RECORD_WALKER_OBJECT_ALLOC_UNIT_MACROS_SVH
`define METAFILE_RECORD_WALKER_OBJECT_ALLOC_UNIT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define MRWOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A condition that must be followed by another in the next cycle.
`define MRWOA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/mrwoa_pkg.sv =====
// Shared types, constants and a helper function for the record walker.
// No dependencies; the front, queue, back and top level refer to it by scoped names.
`timescale 1ns / 1ps

package mrwoa_pkg;

  // Slot table size and its layout as rows of used bits.
  localparam int MAX_SLOTS = 1024;
  localparam int ROW_W     = 32;
  localparam int ROWS      = (MAX_SLOTS + ROW_W - 1) / ROW_W;
  localparam int LANE_W    = $clog2(ROW_W);
  localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W    = ROW_IDX_W + LANE_W;

  // Field widths.
  localparam int CNT_W      = 11;
  localparam int LEN_W      = 32;
  localparam int SIZE_W     = 32;
  localparam int FUNC_W     = 16;
  localparam int PARAM_W    = 16;
  localparam int OUT_SLOT_W = 10;
  localparam int TYPE_W     = 8;

  // Width of the usable slot count and of the compares made against it.
  localparam int N_W     = ($clog2(MAX_SLOTS + 1) > CNT_W) ? $clog2(MAX_SLOTS + 1) : CNT_W;
  localparam int CMP_W   = (SLOT_W > N_W) ? SLOT_W : N_W;
  localparam int PCMP_W  = (PARAM_W > N_W) ? PARAM_W : N_W;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_OBJECT_COUNT = 1'b0;
  localparam logic REG_LIST_LENGTH  = 1'b1;

  // Decoupling queue depth.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Record types (low byte of the function code).
  localparam logic [TYPE_W-1:0] TYPE_EOF    = 8'h00;
  localparam logic [TYPE_W-1:0] TYPE_DELETE = 8'hf0;
  localparam logic [TYPE_W-1:0] TYPE_CR_42  = 8'h42;
  localparam logic [TYPE_W-1:0] TYPE_CR_F7  = 8'hf7;
  localparam logic [TYPE_W-1:0] TYPE_CR_F9  = 8'hf9;
  localparam logic [TYPE_W-1:0] TYPE_CR_FA  = 8'hfa;
  localparam logic [TYPE_W-1:0] TYPE_CR_FB  = 8'hfb;
  localparam logic [TYPE_W-1:0] TYPE_CR_FC  = 8'hfc;
  localparam logic [TYPE_W-1:0] TYPE_CR_FF  = 8'hff;

  // Smallest legal record size in words.
  localparam logic [SIZE_W-1:0] MIN_RECORD_WORDS = 32'd3;

  typedef enum logic [3:0] {
    ST_OTHER   = 4'd0,
    ST_CREATED = 4'd1,
    ST_DELETED = 4'd2,
    ST_DEL_OOR = 4'd3,
    ST_FULL    = 4'd4,
    ST_EOF     = 4'd5,
    ST_BADSIZE = 4'd6,
    ST_END     = 4'd7,
    ST_STOPPED = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_CREATE,
    OP_DELETE
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DEL
  } back_state_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  record_size_words;
    logic [FUNC_W-1:0]  record_function;
    logic [PARAM_W-1:0] first_param;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_SLOT_W-1:0] slot_index;
    logic [LEN_W-1:0]      record_offset_words;
  } out_item_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    op_kind_t          kind;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  offset;
  } q_entry_t;

  // Slots that may be used: the smaller of the configured count and the table size.
  function automatic logic [N_W-1:0] usable_slots(input logic [CNT_W-1:0] count);
    logic [N_W-1:0] c;
    c = N_W'(count);
    return (c < N_W'(MAX_SLOTS)) ? c : N_W'(MAX_SLOTS);
  endfunction

endpackage

// ===== src/mrwoa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mrwoa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/mrwoa_front.sv =====
// Front end: takes record headers, follows the walk position and classifies each request.
// Depends on mrwoa_pkg.
`timescale 1ns / 1ps

module mrwoa_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  mrwoa_pkg::in_item_t             in_item,
  input  logic                            q_full,
  input  logic [mrwoa_pkg::CNT_W-1:0]     object_count,
  input  logic [mrwoa_pkg::LEN_W-1:0]     list_length_words,
  output logic                            push,
  output mrwoa_pkg::q_entry_t             push_entry
);

  logic [mrwoa_pkg::LEN_W-1:0] pos_r, pos_nxt;
  logic                        stopped_r, stopped_nxt;

  logic [mrwoa_pkg::LEN_W:0]     sum;
  logic                          at_end;
  logic [mrwoa_pkg::TYPE_W-1:0]  rec_type;
  logic [mrwoa_pkg::N_W-1:0]     n;
  logic                          is_create;

  assign push     = start && !q_full;
  assign rec_type = in_item.record_function[mrwoa_pkg::TYPE_W-1:0];
  assign n        = mrwoa_pkg::usable_slots(object_count);
  assign sum      = {1'b0, pos_r} + (mrwoa_pkg::LEN_W + 1)'(in_item.record_size_words);
  assign at_end   = (pos_r >= list_length_words) || (sum > {1'b0, list_length_words});

  assign is_create = (rec_type == mrwoa_pkg::TYPE_CR_42) || (rec_type == mrwoa_pkg::TYPE_CR_F7) ||
                     (rec_type == mrwoa_pkg::TYPE_CR_F9) || (rec_type == mrwoa_pkg::TYPE_CR_FA) ||
                     (rec_type == mrwoa_pkg::TYPE_CR_FB) || (rec_type == mrwoa_pkg::TYPE_CR_FC) ||
                     (rec_type == mrwoa_pkg::TYPE_CR_FF);

  always_comb begin
    pos_nxt            = pos_r;
    stopped_nxt        = stopped_r;
    push_entry.kind    = mrwoa_pkg::OP_PASS;
    push_entry.status  = mrwoa_pkg::ST_OTHER;
    push_entry.slot    = '0;
    push_entry.offset  = pos_r;
    if (stopped_r) begin
      push_entry.status = mrwoa_pkg::ST_STOPPED;
    end else if (at_end) begin
      push_entry.status = mrwoa_pkg::ST_END;
      stopped_nxt       = push;
    end else if (in_item.record_size_words < mrwoa_pkg::MIN_RECORD_WORDS) begin
      push_entry.status = mrwoa_pkg::ST_BADSIZE;
      stopped_nxt       = push;
    end else if (rec_type == mrwoa_pkg::TYPE_EOF) begin
      push_entry.status = mrwoa_pkg::ST_EOF;
      stopped_nxt       = push;
    end else begin
      if (push) begin
        pos_nxt = sum[mrwoa_pkg::LEN_W-1:0];
      end
      if (is_create) begin
        if (n == '0) begin
          push_entry.status = mrwoa_pkg::ST_FULL;
        end else begin
          push_entry.kind = mrwoa_pkg::OP_CREATE;
        end
      end else if (rec_type == mrwoa_pkg::TYPE_DELETE) begin
        if (mrwoa_pkg::PCMP_W'(in_item.first_param) < mrwoa_pkg::PCMP_W'(n)) begin
          push_entry.kind = mrwoa_pkg::OP_DELETE;
          push_entry.slot = mrwoa_pkg::SLOT_W'(in_item.first_param);
        end else begin
          push_entry.status = mrwoa_pkg::ST_DEL_OOR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== src/mrwoa_queue.sv =====
// Short request queue that decouples the classifying front from the table back end.
// Depends on mrwoa_pkg.
`timescale 1ns / 1ps

module mrwoa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mrwoa_pkg::q_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output mrwoa_pkg::q_entry_t head
);

  mrwoa_pkg::q_entry_t              slot_r [mrwoa_pkg::QUEUE_DEPTH];
  logic [mrwoa_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mrwoa_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mrwoa_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full       = (count_r == mrwoa_pkg::QCNT_W'(mrwoa_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [mrwoa_pkg::QPTR_W-1:0] ptr_inc(input logic [mrwoa_pkg::QPTR_W-1:0] p);
    return (p == mrwoa_pkg::QPTR_W'(mrwoa_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/mrwoa_back.sv =====
// Back end: carries out create and delete requests on the used-bit table and
// registers every result. Depends on mrwoa_pkg, mrwoa_ram and the assertion macros.
`timescale 1ns / 1ps
`include "metafile_record_walker_object_alloc_unit_macros.svh"

module mrwoa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  mrwoa_pkg::q_entry_t         q_entry,
  output logic                        q_pop,
  input  logic [mrwoa_pkg::CNT_W-1:0] object_count,
  output logic                        out_valid,
  output mrwoa_pkg::out_item_t        out_result
);

  mrwoa_pkg::back_state_t state_r, state_nxt;

  logic [mrwoa_pkg::ROW_IDX_W-1:0] cur_row_r, cur_row_nxt;
  logic [mrwoa_pkg::LANE_W-1:0]    del_lane_r, del_lane_nxt;
  logic [mrwoa_pkg::LEN_W-1:0]     off_r, off_nxt;
  logic [mrwoa_pkg::ROWS-1:0]      row_valid_r, row_valid_nxt;
  logic                            out_valid_r, out_valid_nxt;
  mrwoa_pkg::out_item_t            out_result_r, out_result_nxt;

  logic                            ram_we, ram_re;
  logic [mrwoa_pkg::ROW_IDX_W-1:0] ram_raddr;
  logic [mrwoa_pkg::ROW_W-1:0]     ram_wdata, ram_rdata;

  logic [mrwoa_pkg::N_W-1:0]       n;
  logic [mrwoa_pkg::ROW_IDX_W-1:0] last_row;
  logic [mrwoa_pkg::ROW_W-1:0]     row_eff, beyond, free_vec;
  logic                            found;
  logic [mrwoa_pkg::LANE_W-1:0]    lane;
  logic                            scan_done;

  mrwoa_ram #(
    .WIDTH (mrwoa_pkg::ROW_W),
    .DEPTH (mrwoa_pkg::ROWS)
  ) u_used_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_row_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign n         = mrwoa_pkg::usable_slots(object_count);
  assign last_row  = mrwoa_pkg::ROW_IDX_W'((n - 1'b1) >> mrwoa_pkg::LANE_W);
  // A row never written since reset reads as all slots free.
  assign row_eff   = row_valid_r[cur_row_r] ? ram_rdata : '0;
  assign free_vec  = ~(row_eff | beyond);
  assign scan_done = found || (cur_row_r == last_row);

  // Slots at or above the usable count count as taken.
  always_comb begin
    for (int i = 0; i < mrwoa_pkg::ROW_W; i++) begin
      beyond[i] = mrwoa_pkg::CMP_W'({cur_row_r, mrwoa_pkg::LANE_W'(i)}) >=
                  mrwoa_pkg::CMP_W'(n);
    end
  end

  // Lowest free lane of the current row.
  always_comb begin
    found = 1'b0;
    lane  = '0;
    for (int i = mrwoa_pkg::ROW_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found = 1'b1;
        lane  = mrwoa_pkg::LANE_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrwoa_pkg::BK_IDLE: begin
        if (q_valid) begin
          case (q_entry.kind)
            mrwoa_pkg::OP_CREATE: state_nxt = mrwoa_pkg::BK_SCAN;
            mrwoa_pkg::OP_DELETE: state_nxt = mrwoa_pkg::BK_DEL;
            default:              state_nxt = mrwoa_pkg::BK_IDLE;
          endcase
        end
      end
      mrwoa_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_nxt = mrwoa_pkg::BK_IDLE;
        end
      end
      mrwoa_pkg::BK_DEL: state_nxt = mrwoa_pkg::BK_IDLE;
      default:           state_nxt = mrwoa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = cur_row_r;
    ram_we         = 1'b0;
    ram_wdata      = row_eff;
    cur_row_nxt    = cur_row_r;
    del_lane_nxt   = del_lane_r;
    off_nxt        = off_r;
    row_valid_nxt  = row_valid_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    case (state_r)
      mrwoa_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          off_nxt = q_entry.offset;
          case (q_entry.kind)
            mrwoa_pkg::OP_CREATE: begin
              ram_re      = 1'b1;
              ram_raddr   = '0;
              cur_row_nxt = '0;
            end
            mrwoa_pkg::OP_DELETE: begin
              ram_re       = 1'b1;
              ram_raddr    = q_entry.slot[mrwoa_pkg::SLOT_W-1:mrwoa_pkg::LANE_W];
              cur_row_nxt  = q_entry.slot[mrwoa_pkg::SLOT_W-1:mrwoa_pkg::LANE_W];
              del_lane_nxt = q_entry.slot[mrwoa_pkg::LANE_W-1:0];
            end
            default: begin
              out_valid_nxt                      = 1'b1;
              out_result_nxt.status              = q_entry.status;
              out_result_nxt.slot_index          = '0;
              out_result_nxt.record_offset_words = q_entry.offset;
            end
          endcase
        end
      end
      mrwoa_pkg::BK_SCAN: begin
        if (found) begin
          ram_we                             = 1'b1;
          ram_wdata                          = row_eff | (mrwoa_pkg::ROW_W'(1) << lane);
          row_valid_nxt[cur_row_r]           = 1'b1;
          out_valid_nxt                      = 1'b1;
          out_result_nxt.status              = mrwoa_pkg::ST_CREATED;
          out_result_nxt.slot_index          = mrwoa_pkg::OUT_SLOT_W'({cur_row_r, lane});
          out_result_nxt.record_offset_words = off_r;
        end else if (cur_row_r == last_row) begin
          out_valid_nxt                      = 1'b1;
          out_result_nxt.status              = mrwoa_pkg::ST_FULL;
          out_result_nxt.slot_index          = '0;
          out_result_nxt.record_offset_words = off_r;
        end else begin
          cur_row_nxt = mrwoa_pkg::ROW_IDX_W'(cur_row_r + 1'b1);
          ram_re      = 1'b1;
          ram_raddr   = mrwoa_pkg::ROW_IDX_W'(cur_row_r + 1'b1);
        end
      end
      mrwoa_pkg::BK_DEL: begin
        ram_we                             = 1'b1;
        ram_wdata                          = row_eff & ~(mrwoa_pkg::ROW_W'(1) << del_lane_r);
        row_valid_nxt[cur_row_r]           = 1'b1;
        out_valid_nxt                      = 1'b1;
        out_result_nxt.status              = mrwoa_pkg::ST_DELETED;
        out_result_nxt.slot_index          = mrwoa_pkg::OUT_SLOT_W'({cur_row_r, del_lane_r});
        out_result_nxt.record_offset_words = off_r;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrwoa_pkg::BK_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r    <= cur_row_nxt;
    del_lane_r   <= del_lane_nxt;
    off_r        <= off_nxt;
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  `MRWOA_ASSERT(a_scan_row_in_range, (state_r == mrwoa_pkg::BK_SCAN) |-> (cur_row_r <= last_row), "scan ran past the last usable row")
  `MRWOA_ASSERT(a_no_read_on_write, !(ram_we && ram_re), "table read and write in the same cycle")
  `MRWOA_ASSERT(a_slot_zero_otherwise, (out_valid_r && (out_result_r.status != mrwoa_pkg::ST_CREATED) && (out_result_r.status != mrwoa_pkg::ST_DELETED)) |-> (out_result_r.slot_index == '0), "slot index set on a result without a slot")
  `MRWOA_ASSERT_NEXT(a_delete_one_cycle, state_r == mrwoa_pkg::BK_DEL, (state_r == mrwoa_pkg::BK_IDLE) && out_valid_r, "delete did not finish with a result")

endmodule

// ===== src/metafile_record_walker_object_alloc_unit.sv =====
// Top level of the record walker with lowest-free-slot object allocator.
// Depends on mrwoa_pkg, mrwoa_front, mrwoa_queue, mrwoa_back and mrwoa_ram.
`timescale 1ns / 1ps

// The block walks a record list one header at a time. A request is taken on
// a rising edge with start high and busy low; every request yields exactly
// one result, shown for a single cycle with out_valid high, in request order.
// The receiver cannot stall, so a result must be captured in the cycle it is
// shown. With the back end free, a request that needs no table work (end
// of walk, bad size, end of file, other types, out-of-range delete, create
// with a zero count) takes a queue entry and then the result register.
// A delete reads its row of the table, then writes it back with the slot
// cleared and registers its result. A create scans the used-bit table
// one 32-slot row per cycle, up to the last usable row; that scan through
// the single read port of the table memory sets the rate. A request that
// waits in the queue behind earlier ones adds their back-end time. The front
// end classifies and moves the walk position on at once, and a two-entry
// queue lets it take further requests while a scan runs; busy is high only
// while that queue is full. The table is clear straight after reset, held by
// one valid bit per row, so there is no clearing pass. Configuration writes
// are to be made only while no request is outstanding.
module metafile_record_walker_object_alloc_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             start,
  output logic                             busy,
  input  mrwoa_pkg::in_item_t              in_item,
  // result channel
  output logic                             out_valid,
  output mrwoa_pkg::out_item_t             out_result,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mrwoa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mrwoa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mrwoa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  // Configuration registers: usable object count and list length.
  logic [mrwoa_pkg::CNT_W-1:0] object_count_r, object_count_nxt;
  logic [mrwoa_pkg::LEN_W-1:0] list_length_r, list_length_nxt;
  logic                        cfg_write;
  logic                        cfg_index;

  // Front to queue and queue to back.
  logic                q_full;
  logic                push;
  mrwoa_pkg::q_entry_t push_entry;
  logic                head_valid;
  mrwoa_pkg::q_entry_t head;
  logic                pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[mrwoa_pkg::CFG_ADDR_W-1];

  always_comb begin
    object_count_nxt = object_count_r;
    list_length_nxt  = list_length_r;
    if (cfg_write) begin
      case (cfg_index)
        mrwoa_pkg::REG_OBJECT_COUNT: object_count_nxt = pwdata[mrwoa_pkg::CNT_W-1:0];
        mrwoa_pkg::REG_LIST_LENGTH:  list_length_nxt  = pwdata[mrwoa_pkg::LEN_W-1:0];
        default:                     list_length_nxt  = list_length_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      mrwoa_pkg::REG_OBJECT_COUNT: prdata = mrwoa_pkg::CFG_DATA_W'(object_count_r);
      mrwoa_pkg::REG_LIST_LENGTH:  prdata = mrwoa_pkg::CFG_DATA_W'(list_length_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_count_r <= '0;
      list_length_r  <= '0;
    end else begin
      object_count_r <= object_count_nxt;
      list_length_r  <= list_length_nxt;
    end
  end

  // A request is refused only while the queue to the back end is full.
  assign busy = q_full;

  mrwoa_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_item           (in_item),
    .q_full            (q_full),
    .object_count      (object_count_r),
    .list_length_words (list_length_r),
    .push              (push),
    .push_entry        (push_entry)
  );

  mrwoa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  mrwoa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (head_valid),
    .q_entry      (head),
    .q_pop        (pop),
    .object_count (object_count_r),
    .out_valid    (out_valid),
    .out_result   (out_result)
  );

endmodule
